>>> rtl/asi_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and helper functions for the arrive
// steering integrator. Used by the channel interfaces and the top level.
package asi_pkg;

    localparam int COORD_W     = 32;
    localparam int SPEED_W     = 23;
    localparam int FORCE_W     = 23;
    localparam int RADIUS_W    = 27;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 27;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_SPEED   = 2'd0,
        REG_MAX_FORCE   = 2'd1,
        REG_SLOW_RADIUS = 2'd2,
        REG_UNUSED      = 2'd3
    } cfg_reg_t;

    function automatic logic [33:0] mag34(input logic signed [33:0] v);
        logic [33:0] r;
        r = v[33] ? 34'(-v) : 34'(v);
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if ((v[34:31] == 4'b0000) || (v[34:31] == 4'b1111))
        begin
            r = v[31:0];
        end
        else
        begin
            r = v[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic signed [33:0] apply_sign(input logic neg,
                                                      input logic [32:0] m);
        logic signed [33:0] r;
        r = $signed({1'b0, m});
        if (neg)
        begin
            r = -r;
        end
        return r;
    endfunction

endpackage

>>> rtl/asi_target_if.sv
`timescale 1ns / 1ps
// Request channel that carries one target point per frame tick.
// Depends on asi_pkg for the coordinate width.
interface asi_target_if;
    logic                                valid;
    logic                                ready;
    logic signed [asi_pkg::COORD_W-1:0]  target_x;
    logic signed [asi_pkg::COORD_W-1:0]  target_y;

    modport source (output valid, output target_x, output target_y, input ready);
    modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

>>> rtl/asi_result_if.sv
`timescale 1ns / 1ps
// Result channel that carries the updated state of one frame tick.
// Depends on asi_pkg for the coordinate width.
interface asi_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [asi_pkg::COORD_W-1:0]  pos_x;
    logic signed [asi_pkg::COORD_W-1:0]  pos_y;
    logic signed [asi_pkg::COORD_W-1:0]  vel_x;
    logic signed [asi_pkg::COORD_W-1:0]  vel_y;
    logic signed [asi_pkg::COORD_W-1:0]  acc_x;
    logic signed [asi_pkg::COORD_W-1:0]  acc_y;
    logic                                snapped;

    modport source (output valid, output pos_x, output pos_y, output vel_x,
                    output vel_y, output acc_x, output acc_y, output snapped,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input vel_x,
                    input vel_y, input acc_x, input acc_y, input snapped,
                    output ready);
endinterface

>>> rtl/asi_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on asi_pkg for the index and data widths.
interface asi_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [asi_pkg::CFG_IDX_W-1:0]      index;
    logic [asi_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/arrive_steering_integrator_unit.sv
`timescale 1ns / 1ps
// Top level of the arrive steering integrator: sequencer, shared multiplier,
// square root and divider. Depends on asi_pkg and the three channel interfaces.
//
// One target request moves a point mass one tick toward the target and
// returns its position, velocity, applied acceleration and a snap flag. The
// block takes one request at a time. A request that snaps needs one length
// and no division; an ordinary one needs two lengths and two divisions, and
// up to five divisions when the speed is scaled inside the slowing radius
// and the force is clamped. The time is set by one shared restoring divider
// and one shared bit-pair square root. A finished result waits in an output
// register while the next request is already being worked on.
// Configuration writes are taken at any time and must only be made while
// the block is idle.
module arrive_steering_integrator_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    asi_target_if.sink   target_ch,
    asi_result_if.source result_ch,
    asi_cfg_if.sink      cfg_ch
);

    localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
    localparam longint SNAP_Q     = (ONE_Q + 50) / 100;
    localparam longint SPEED_Q    = longint'(10) << FRAC_BITS;
    localparam longint FORCE_Q    = ((longint'(6) << FRAC_BITS) + 5) / 10;
    localparam longint RADIUS_Q   = longint'(100) << FRAC_BITS;
    localparam longint POS_Q      = longint'(510) << FRAC_BITS;
    localparam longint SPEED_MAXV = (longint'(1) << asi_pkg::SPEED_W) - 1;
    localparam longint FORCE_MAXV = (longint'(1) << asi_pkg::FORCE_W) - 1;
    localparam longint RAD_MAXV   = (longint'(1) << asi_pkg::RADIUS_W) - 1;
    localparam longint POS_MAXV   = longint'(2147483647);
    localparam logic [asi_pkg::SPEED_W-1:0] SPEED_RST =
        asi_pkg::SPEED_W'((SPEED_Q > SPEED_MAXV) ? SPEED_MAXV : SPEED_Q);
    localparam logic [asi_pkg::FORCE_W-1:0] FORCE_RST =
        asi_pkg::FORCE_W'((FORCE_Q > FORCE_MAXV) ? FORCE_MAXV : FORCE_Q);
    localparam logic [asi_pkg::RADIUS_W-1:0] RADIUS_RST =
        asi_pkg::RADIUS_W'((RADIUS_Q > RAD_MAXV) ? RAD_MAXV : RADIUS_Q);
    localparam logic [31:0] POS_RST = 32'((POS_Q > POS_MAXV) ? POS_MAXV : POS_Q);
    localparam logic [34:0] SNAP_THR = 35'(SNAP_Q);
    localparam logic [5:0]  DIV_STEPS = 6'd56;

    typedef enum logic [4:0] {
        S_IDLE, S_SHIFT, S_SQA, S_SQB, S_ADD, S_SQRT, S_SPD_MUL, S_DIV, S_DIV_END,
        S_WX_MUL, S_WY_MUL, S_ACC, S_CX_MUL, S_CY_MUL, S_VEL, S_POS, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        DT_SPEED, DT_WX, DT_WY, DT_CX, DT_CY
    } div_tag_t;

    state_t                      state_reg;
    div_tag_t                    div_tag_reg;
    logic                        len_tag_reg;
    logic [asi_pkg::SPEED_W-1:0] max_speed_reg;
    logic [asi_pkg::FORCE_W-1:0] max_force_reg;
    logic [asi_pkg::RADIUS_W-1:0] slow_radius_reg;
    logic [31:0]                 pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic [31:0]                 tx_reg, ty_reg;
    logic signed [33:0]          dx_reg, dy_reg, wx_reg, wy_reg, ax_reg, ay_reg;
    logic [31:0]                 acc_x_reg, acc_y_reg;
    logic                        snap_reg;
    logic [33:0]                 la_reg, lb_reg;
    logic [1:0]                  sh_reg;
    logic [64:0]                 prod_reg;
    logic [63:0]                 rad_reg, root_reg, bit_reg;
    logic [34:0]                 d_reg, alen_reg;
    logic [asi_pkg::SPEED_W-1:0] speed_reg;
    logic [56:0]                 div_n_reg, div_q_reg;
    logic [34:0]                 div_r_reg, div_den_reg;
    logic [5:0]                  div_cnt_reg;
    logic                        out_valid_reg;
    logic [31:0]                 o_pos_x_reg, o_pos_y_reg, o_vel_x_reg, o_vel_y_reg;
    logic [31:0]                 o_acc_x_reg, o_acc_y_reg;
    logic                        o_snap_reg;

    logic [33:0]        mul_a;
    logic [30:0]        mul_b;
    logic [64:0]        mul_p;
    logic signed [33:0] diff_x, diff_y, acc_nx, acc_ny;
    logic [63:0]        sq_sum;
    logic [34:0]        len_val;
    logic [35:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        vel_nx, vel_ny;
    logic [31:0]        base_x, base_y;
    logic               in_take, out_take;

    assign in_take  = target_ch.valid && target_ch.ready;
    assign out_take = result_ch.valid && result_ch.ready;
    assign target_ch.ready = (state_reg == S_IDLE);
    assign cfg_ch.ready    = 1'b1;

    assign diff_x = 34'(target_ch.target_x) - 34'($signed(pos_x_reg));
    assign diff_y = 34'(target_ch.target_y) - 34'($signed(pos_y_reg));
    assign acc_nx = wx_reg - 34'($signed(vel_x_reg));
    assign acc_ny = wy_reg - 34'($signed(vel_y_reg));
    assign sq_sum  = root_reg + bit_reg;
    assign len_val = 35'(root_reg[31:0]) << sh_reg;
    assign rem_sh  = {div_r_reg, div_n_reg[56]};
    assign rem_ge  = (rem_sh >= {1'b0, div_den_reg});
    assign vel_nx  = asi_pkg::sat32(35'($signed(vel_x_reg)) + 35'($signed(acc_x_reg)));
    assign vel_ny  = asi_pkg::sat32(35'($signed(vel_y_reg)) + 35'($signed(acc_y_reg)));
    assign base_x  = snap_reg ? tx_reg : pos_x_reg;
    assign base_y  = snap_reg ? ty_reg : pos_y_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQA:     begin mul_a = la_reg; mul_b = la_reg[30:0]; end
            S_SQB:     begin mul_a = lb_reg; mul_b = lb_reg[30:0]; end
            S_SPD_MUL: begin mul_a = d_reg[33:0]; mul_b = 31'(max_speed_reg); end
            S_WX_MUL:  begin mul_a = asi_pkg::mag34(dx_reg); mul_b = 31'(speed_reg); end
            S_WY_MUL:  begin mul_a = asi_pkg::mag34(dy_reg); mul_b = 31'(speed_reg); end
            S_CX_MUL:  begin mul_a = asi_pkg::mag34(ax_reg); mul_b = 31'(max_force_reg); end
            S_CY_MUL:  begin mul_a = asi_pkg::mag34(ay_reg); mul_b = 31'(max_force_reg); end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg   <= SPEED_RST;
            max_force_reg   <= FORCE_RST;
            slow_radius_reg <= RADIUS_RST;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (asi_pkg::cfg_reg_t'(cfg_ch.index))
                asi_pkg::REG_MAX_SPEED:   max_speed_reg   <= cfg_ch.data[asi_pkg::SPEED_W-1:0];
                asi_pkg::REG_MAX_FORCE:   max_force_reg   <= cfg_ch.data[asi_pkg::FORCE_W-1:0];
                asi_pkg::REG_SLOW_RADIUS: slow_radius_reg <= cfg_ch.data[asi_pkg::RADIUS_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_tag_reg   <= DT_SPEED;
            len_tag_reg   <= 1'b0;
            pos_x_reg     <= POS_RST;
            pos_y_reg     <= POS_RST;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        tx_reg      <= target_ch.target_x;
                        ty_reg      <= target_ch.target_y;
                        dx_reg      <= diff_x;
                        dy_reg      <= diff_y;
                        la_reg      <= asi_pkg::mag34(diff_x);
                        lb_reg      <= asi_pkg::mag34(diff_y);
                        sh_reg      <= '0;
                        len_tag_reg <= 1'b0;
                        state_reg   <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if ((la_reg[33:31] != 3'b000) || (lb_reg[33:31] != 3'b000))
                    begin
                        la_reg <= la_reg >> 1;
                        lb_reg <= lb_reg >> 1;
                        sh_reg <= sh_reg + 2'd1;
                    end
                    else
                    begin
                        state_reg <= S_SQA;
                    end
                end
                S_SQA:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SQB;
                end
                S_SQB:
                begin
                    rad_reg   <= prod_reg[63:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    rad_reg   <= rad_reg + prod_reg[63:0];
                    root_reg  <= '0;
                    bit_reg   <= 64'd1 << 62;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (bit_reg != '0)
                    begin
                        if (rad_reg >= sq_sum)
                        begin
                            rad_reg  <= rad_reg - sq_sum;
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                    else if (!len_tag_reg)
                    begin
                        d_reg <= len_val;
                        if (len_val < SNAP_THR)
                        begin
                            snap_reg  <= 1'b1;
                            acc_x_reg <= '0;
                            acc_y_reg <= '0;
                            state_reg <= S_VEL;
                        end
                        else if (len_val < 35'(slow_radius_reg))
                        begin
                            snap_reg  <= 1'b0;
                            state_reg <= S_SPD_MUL;
                        end
                        else
                        begin
                            snap_reg  <= 1'b0;
                            speed_reg <= max_speed_reg;
                            state_reg <= S_WX_MUL;
                        end
                    end
                    else
                    begin
                        alen_reg <= len_val;
                        if (len_val > 35'(max_force_reg))
                        begin
                            state_reg <= S_CX_MUL;
                        end
                        else
                        begin
                            acc_x_reg <= asi_pkg::sat32(35'(ax_reg));
                            acc_y_reg <= asi_pkg::sat32(35'(ay_reg));
                            state_reg <= S_VEL;
                        end
                    end
                end
                S_SPD_MUL, S_WX_MUL, S_WY_MUL, S_CX_MUL, S_CY_MUL:
                begin
                    div_n_reg   <= mul_p[56:0];
                    div_q_reg   <= '0;
                    div_r_reg   <= '0;
                    div_cnt_reg <= DIV_STEPS;
                    state_reg   <= S_DIV;
                    priority case (state_reg)
                        S_SPD_MUL:
                        begin
                            div_den_reg <= 35'(slow_radius_reg);
                            div_tag_reg <= DT_SPEED;
                        end
                        S_WX_MUL:
                        begin
                            div_den_reg <= d_reg;
                            div_tag_reg <= DT_WX;
                        end
                        S_WY_MUL:
                        begin
                            div_den_reg <= d_reg;
                            div_tag_reg <= DT_WY;
                        end
                        S_CX_MUL:
                        begin
                            div_den_reg <= alen_reg;
                            div_tag_reg <= DT_CX;
                        end
                        default:
                        begin
                            div_den_reg <= alen_reg;
                            div_tag_reg <= DT_CY;
                        end
                    endcase
                end
                S_DIV:
                begin
                    div_n_reg <= div_n_reg << 1;
                    div_q_reg <= {div_q_reg[55:0], rem_ge};
                    div_r_reg <= rem_ge ? 35'(rem_sh - {1'b0, div_den_reg}) : rem_sh[34:0];
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= S_DIV_END;
                    end
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                end
                S_DIV_END:
                begin
                    unique case (div_tag_reg)
                        DT_SPEED:
                        begin
                            speed_reg <= div_q_reg[asi_pkg::SPEED_W-1:0];
                            state_reg <= S_WX_MUL;
                        end
                        DT_WX:
                        begin
                            wx_reg    <= asi_pkg::apply_sign(dx_reg[33], div_q_reg[32:0]);
                            state_reg <= S_WY_MUL;
                        end
                        DT_WY:
                        begin
                            wy_reg    <= asi_pkg::apply_sign(dy_reg[33], div_q_reg[32:0]);
                            state_reg <= S_ACC;
                        end
                        DT_CX:
                        begin
                            acc_x_reg <= asi_pkg::sat32(35'(asi_pkg::apply_sign(ax_reg[33],
                                                                div_q_reg[32:0])));
                            state_reg <= S_CY_MUL;
                        end
                        DT_CY:
                        begin
                            acc_y_reg <= asi_pkg::sat32(35'(asi_pkg::apply_sign(ay_reg[33],
                                                                div_q_reg[32:0])));
                            state_reg <= S_VEL;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_ACC:
                begin
                    ax_reg      <= acc_nx;
                    ay_reg      <= acc_ny;
                    la_reg      <= asi_pkg::mag34(acc_nx);
                    lb_reg      <= asi_pkg::mag34(acc_ny);
                    sh_reg      <= '0;
                    len_tag_reg <= 1'b1;
                    state_reg   <= S_SHIFT;
                end
                S_VEL:
                begin
                    vel_x_reg <= vel_nx;
                    vel_y_reg <= vel_ny;
                    state_reg <= S_POS;
                end
                S_POS:
                begin
                    pos_x_reg <= asi_pkg::sat32(35'($signed(base_x)) + 35'($signed(vel_x_reg)));
                    pos_y_reg <= asi_pkg::sat32(35'($signed(base_y)) + 35'($signed(vel_y_reg)));
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || result_ch.ready)
                    begin
                        o_pos_x_reg   <= pos_x_reg;
                        o_pos_y_reg   <= pos_y_reg;
                        o_vel_x_reg   <= vel_x_reg;
                        o_vel_y_reg   <= vel_y_reg;
                        o_acc_x_reg   <= acc_x_reg;
                        o_acc_y_reg   <= acc_y_reg;
                        o_snap_reg    <= snap_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.pos_x   = o_pos_x_reg;
    assign result_ch.pos_y   = o_pos_y_reg;
    assign result_ch.vel_x   = o_vel_x_reg;
    assign result_ch.vel_y   = o_vel_y_reg;
    assign result_ch.acc_x   = o_acc_x_reg;
    assign result_ch.acc_y   = o_acc_y_reg;
    assign result_ch.snapped = o_snap_reg;

    // A snapped tick never applies any acceleration.
    a_snap_no_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.snapped) |-> (result_ch.acc_x == '0 &&
                                                    result_ch.acc_y == '0))
        else $error("snapped result carries nonzero acceleration");

    // Once a request is taken, no further request is taken until it finishes.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !target_ch.ready)
        else $error("request accepted while another is in progress");

    // The shared divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_den_reg != '0))
        else $error("divider started with zero divisor");

endmodule

>>> dv/arrive_steering_integrator_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the arrive steering integrator: drives target requests and
// register writes, predicts each result with its own steering model and checks
// every field in order. Depends on asi_pkg and the three channel interfaces.

class steer_scoreboard;
    longint unsigned speed_q;
    longint unsigned force_q;
    longint unsigned radius_q;
    longint px;
    longint py;
    longint vx;
    longint vy;
    logic [31:0] exp_px[$];
    logic [31:0] exp_py[$];
    logic [31:0] exp_vx[$];
    logic [31:0] exp_vy[$];
    logic [31:0] exp_ax[$];
    logic [31:0] exp_ay[$];
    bit exp_snap[$];
    int mismatches;
    int checked;
    int snaps;

    function new();
        speed_q = 64'd655360;
        force_q = 64'd39322;
        radius_q = 64'd6553600;
        px = 64'd33423360;
        py = 64'd33423360;
        vx = 0;
        vy = 0;
        mismatches = 0;
        checked = 0;
        snaps = 0;
    endfunction

    function longint clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function longint unsigned root_floor(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function longint unsigned length_of(longint a, longint b);
        longint unsigned ua;
        longint unsigned ub;
        int s;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        s = 0;
        while (ua >= 64'h8000_0000 || ub >= 64'h8000_0000)
        begin
            ua = ua >> 1;
            ub = ub >> 1;
            s++;
        end
        return root_floor(ua * ua + ub * ub) << s;
    endfunction

    function void set_reg(asi_pkg::cfg_reg_t idx, logic [26:0] val);
        case (idx)
            asi_pkg::REG_MAX_SPEED:   speed_q = val[22:0];
            asi_pkg::REG_MAX_FORCE:   force_q = val[22:0];
            asi_pkg::REG_SLOW_RADIUS: radius_q = val;
            default: ;
        endcase
    endfunction

    function void note_target(logic signed [31:0] tx, logic signed [31:0] ty);
        longint dx;
        longint dy;
        longint ax;
        longint ay;
        longint wx;
        longint wy;
        longint unsigned d;
        longint unsigned spd;
        longint unsigned alen;
        bit snap;
        dx = longint'(tx) - px;
        dy = longint'(ty) - py;
        d = length_of(dx, dy);
        ax = 0;
        ay = 0;
        if (d >= 64'd655)
        begin
            spd = speed_q;
            if (d < radius_q)
            begin
                spd = (speed_q * d) / radius_q;
            end
            wx = (dx * longint'(spd)) / longint'(d);
            wy = (dy * longint'(spd)) / longint'(d);
            ax = wx - vx;
            ay = wy - vy;
            alen = length_of(ax, ay);
            if (alen > force_q)
            begin
                ax = (ax * longint'(force_q)) / longint'(alen);
                ay = (ay * longint'(force_q)) / longint'(alen);
            end
            ax = clip32(ax);
            ay = clip32(ay);
            snap = 0;
        end
        else
        begin
            px = tx;
            py = ty;
            snap = 1;
        end
        vx = clip32(vx + ax);
        vy = clip32(vy + ay);
        px = clip32(px + vx);
        py = clip32(py + vy);
        exp_px.push_back(px[31:0]);
        exp_py.push_back(py[31:0]);
        exp_vx.push_back(vx[31:0]);
        exp_vy.push_back(vy[31:0]);
        exp_ax.push_back(ax[31:0]);
        exp_ay.push_back(ay[31:0]);
        exp_snap.push_back(snap);
    endfunction

    function void check_result(logic [31:0] rpx, logic [31:0] rpy, logic [31:0] rvx,
                               logic [31:0] rvy, logic [31:0] rax, logic [31:0] ray,
                               logic rsnap);
        logic [31:0] e[6];
        logic [31:0] g[6];
        bit es;
        bit bad;
        if (exp_px.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Result with no request pending: pos %h %h", rpx, rpy);
            end
            return;
        end
        e[0] = exp_px.pop_front();
        e[1] = exp_py.pop_front();
        e[2] = exp_vx.pop_front();
        e[3] = exp_vy.pop_front();
        e[4] = exp_ax.pop_front();
        e[5] = exp_ay.pop_front();
        es = exp_snap.pop_front();
        g = '{rpx, rpy, rvx, rvy, rax, ray};
        checked++;
        if (es)
        begin
            snaps++;
        end
        bad = (rsnap !== es);
        for (int i = 0; i < 6; i++)
        begin
            if (g[i] !== e[i])
            begin
                bad = 1;
            end
        end
        if (bad)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("Mismatch on result %0d: expected pos %h %h vel %h %h acc %h %h snap %b",
                         checked, e[0], e[1], e[2], e[3], e[4], e[5], es);
                $display("    actual pos %h %h vel %h %h acc %h %h snap %b",
                         g[0], g[1], g[2], g[3], g[4], g[5], rsnap);
            end
        end
    endfunction

    function int pending();
        return exp_px.size();
    endfunction
endclass

module arrive_steering_integrator_unit_tb;

    localparam int IDLE_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int requests_sent;
    bit timed_out;
    steer_scoreboard board;

    asi_target_if target_ch();
    asi_result_if result_ch();
    asi_cfg_if    cfg_ch();

    arrive_steering_integrator_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .target_ch (target_ch.sink),
        .result_ch (result_ch.source),
        .cfg_ch    (cfg_ch.sink)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
        begin
            board.check_result(result_ch.pos_x, result_ch.pos_y, result_ch.vel_x,
                               result_ch.vel_y, result_ch.acc_x, result_ch.acc_y,
                               result_ch.snapped);
        end
        if ((target_ch.valid && target_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
    end

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        if (idle_cycles >= IDLE_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("Watchdog expired with %0d results pending", board.pending());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(asi_pkg::cfg_reg_t idx, logic [26:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_target(logic [31:0] tx, logic [31:0] ty);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
        end
        target_ch.valid    = 1'b1;
        target_ch.target_x = tx;
        target_ch.target_y = ty;
        @(posedge clk);
        while (!target_ch.ready)
        begin
            @(posedge clk);
        end
        board.note_target(tx, ty);
        requests_sent++;
        @(negedge clk);
        target_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (500)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [31:0] near_point(longint c, int spread);
        longint v;
        v = c + $signed($urandom_range(2 * spread)) - spread;
        if (v > 64'sd2147483647)
        begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    task automatic random_block(int count);
        int kind;
        logic [31:0] tx;
        logic [31:0] ty;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(9);
            case (kind)
                0, 1, 2:
                begin
                    tx = near_point(board.px, 1 << ($urandom_range(24)));
                    ty = near_point(board.py, 1 << ($urandom_range(24)));
                end
                3:
                begin
                    tx = near_point(board.px, 300);
                    ty = near_point(board.py, 300);
                end
                4, 5:
                begin
                    tx = $urandom;
                    ty = $urandom;
                end
                6:
                begin
                    tx = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    ty = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                end
                default:
                begin
                    tx = near_point(board.px, 1 << 20);
                    ty = near_point(board.py, 1 << 20);
                end
            endcase
            send_target(tx, ty);
        end
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        idle_cycles = 0;
        requests_sent = 0;
        timed_out = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        target_ch.valid = 1'b0;
        target_ch.target_x = '0;
        target_ch.target_y = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = asi_pkg::REG_MAX_SPEED;
        cfg_ch.data = '0;
        repeat (5)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests with the reset settings.
        send_target(32'd33423360, 32'd33423360);
        send_target(board.px[31:0] + 32'd100, board.py[31:0]);
        send_target(32'd0, 32'd0);
        send_target(32'h7FFF_FFFF, 32'h8000_0000);
        send_target(32'h8000_0000, 32'h7FFF_FFFF);
        send_target(32'h8000_0000, 32'h8000_0000);
        send_target(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_target(board.px[31:0], board.py[31:0] + 32'd654);
        send_target(board.px[31:0] + 32'd655, board.py[31:0]);
        send_target(32'hFFFF_FFFF, 32'h0000_0001);
        send_target(32'h5555_5555, 32'hAAAA_AAAA);
        drain();

        write_reg(asi_pkg::REG_MAX_SPEED, 27'h7F_FFFF);
        write_reg(asi_pkg::REG_MAX_FORCE, 27'h7F_FFFF);
        write_reg(asi_pkg::REG_SLOW_RADIUS, 27'h7FF_FFFF);
        write_reg(asi_pkg::REG_UNUSED, 27'h123_4567);
        send_target(32'h8000_0000, 32'h8000_0000);
        send_target(32'h7FFF_FFFF, 32'h0000_0000);
        send_target(32'd0, 32'd0);
        drain();
        write_reg(asi_pkg::REG_MAX_SPEED, 27'd0);
        write_reg(asi_pkg::REG_MAX_FORCE, 27'd0);
        write_reg(asi_pkg::REG_SLOW_RADIUS, 27'd0);
        send_target(32'd1000000, 32'hFFF0_0000);
        send_target(32'd0, 32'd0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            case (phase)
                0: begin
                    write_reg(asi_pkg::REG_MAX_SPEED, 27'd655360);
                    write_reg(asi_pkg::REG_MAX_FORCE, 27'd39322);
                    write_reg(asi_pkg::REG_SLOW_RADIUS, 27'd6553600);
                end
                3: begin
                    write_reg(asi_pkg::REG_MAX_SPEED, 27'h40_0000);
                    write_reg(asi_pkg::REG_MAX_FORCE, 27'h40_0000);
                    write_reg(asi_pkg::REG_SLOW_RADIUS, 27'h1_0000);
                end
                7: begin
                    write_reg(asi_pkg::REG_MAX_SPEED, 27'h7F_FFFF);
                    write_reg(asi_pkg::REG_MAX_FORCE, 27'd1);
                    write_reg(asi_pkg::REG_SLOW_RADIUS, 27'h400_0000);
                end
                default: begin
                    write_reg(asi_pkg::REG_MAX_SPEED, 27'($urandom_range(27'h40_0000)));
                    write_reg(asi_pkg::REG_MAX_FORCE, 27'($urandom_range(27'h40_0000)));
                    write_reg(asi_pkg::REG_SLOW_RADIUS,
                              27'($urandom_range(27'h400_0000, 27'h1_0000)));
                end
            endcase
            random_block(58);
            // Hold off until every pending result is back, then continue.
            while (board.pending() != 0)
            begin
                @(negedge clk);
            end
            random_block(58);
            drain();
        end

        $display("Sent %0d target requests, checked %0d results, %0d of them snapped.",
                 requests_sent, board.checked, board.snaps);
        if (board.mismatches == 0 && board.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("Mismatches: %0d, results missing: %0d", board.mismatches,
                     board.pending());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
